@@ rtl/core/scpf_pkg.sv @@
// ============================================================================
// scpf_pkg
// Shared types and codes of the servo command packet framer: operation codes,
// control table addresses, read kinds and the packet descriptor that the
// front part hands to the back part.
// ============================================================================
`default_nettype none

package scpf_pkg;

    localparam int STATUS_BYTES = 8;
    localparam int BODY_MAX     = 10;

    // operation codes
    localparam logic [3:0] OP_SYNC_MOVE = 4'd0;
    localparam logic [3:0] OP_POSITION  = 4'd1;
    localparam logic [3:0] OP_SPEED     = 4'd2;
    localparam logic [3:0] OP_TORQUE    = 4'd3;
    localparam logic [3:0] OP_LED       = 4'd4;
    localparam logic [3:0] OP_SET_ID    = 4'd5;
    localparam logic [3:0] OP_READ_ID   = 4'd6;
    localparam logic [3:0] OP_READ_POS  = 4'd7;
    localparam logic [3:0] OP_READ_TEMP = 4'd8;
    localparam logic [3:0] OP_READ_LOAD = 4'd9;
    localparam logic [3:0] OP_RX_BYTE   = 4'd10;

    // read kinds held while the receiver is armed
    localparam logic [2:0] RD_NONE = 3'd0;
    localparam logic [2:0] RD_ID   = 3'd1;
    localparam logic [2:0] RD_POS  = 3'd2;
    localparam logic [2:0] RD_TEMP = 3'd3;
    localparam logic [2:0] RD_LOAD = 3'd4;

    // packet bytes
    localparam logic [7:0] HDR_BYTE       = 8'hFF;
    localparam logic [7:0] BROADCAST_ID   = 8'hFE;
    localparam logic [7:0] INST_READ      = 8'h02;
    localparam logic [7:0] INST_WRITE     = 8'h03;
    localparam logic [7:0] INST_SYNC      = 8'h83;
    localparam logic [7:0] LEN_SYNC       = 8'h09;
    localparam logic [7:0] LEN_WRITE_WORD = 8'h05;
    localparam logic [7:0] LEN_SHORT      = 8'h04;
    localparam logic [7:0] SYNC_DATA_LEN  = 8'h04;

    // control table addresses
    localparam logic [7:0] ADDR_ID        = 8'h03;
    localparam logic [7:0] ADDR_GOAL_POS  = 8'h1E;
    localparam logic [7:0] ADDR_SPEED     = 8'h20;
    localparam logic [7:0] ADDR_TORQUE    = 8'h18;
    localparam logic [7:0] ADDR_LED       = 8'h19;
    localparam logic [7:0] ADDR_PRES_POS  = 8'h24;
    localparam logic [7:0] ADDR_PRES_TEMP = 8'h2B;
    localparam logic [7:0] ADDR_PRES_LOAD = 8'h28;

    localparam logic RESULT_TX   = 1'b0;
    localparam logic RESULT_READ = 1'b1;

    typedef struct packed {
        logic                         is_read;
        logic [BODY_MAX-1:0][7:0]     body;      // body[0] goes out first
        logic [3:0]                   body_len;
        logic [15:0]                  read_value;
        logic                         header_ok;
    } scpf_desc_t;

    typedef struct packed {
        logic       valid;
        scpf_desc_t desc;
    } scpf_push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } scpf_qstat_t;

endpackage

`default_nettype wire

@@ rtl/core/scpf_cmd_if.sv @@
// ============================================================================
// scpf_cmd_if
// Command channel: valid/ready handshake with the command and receive fields.
// ============================================================================
`default_nettype none

interface scpf_cmd_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic [7:0]         servo_id;
    logic signed [15:0] position_value;
    logic [15:0]        speed_value;
    logic [7:0]         setting_value;
    logic [7:0]         received_byte;

    modport source (
        output valid, operation, servo_id, position_value, speed_value,
               setting_value, received_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, servo_id, position_value, speed_value,
               setting_value, received_byte,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/scpf_res_if.sv @@
// ============================================================================
// scpf_res_if
// Result channel: valid/ready handshake with transmit byte or read result.
// ============================================================================
`default_nettype none

interface scpf_res_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [7:0]         tx_byte;
    logic               last_byte;
    logic signed [15:0] read_value;
    logic               header_ok;

    modport source (
        output valid, result_kind, tx_byte, last_byte, read_value, header_ok,
        input  ready
    );
    modport sink (
        input  valid, result_kind, tx_byte, last_byte, read_value, header_ok,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/servo_command_packet_framer_unit.sv @@
// ============================================================================
// servo_command_packet_framer_unit
// Servo packet engine: frames command packets byte by byte and decodes the
// status packet that answers a read command.
// ============================================================================
//
//  channel  dir  handshake      payload
//  cmd      in   valid/ready    operation, servo_id, position_value,
//                               speed_value, setting_value, received_byte
//  res      out  valid/ready    result_kind, tx_byte, last_byte,
//                               read_value, header_ok
//
//  A command packet leaves one byte per cycle while res is not stalled: 8 to
//  13 bytes, as the back serializer steps through header, body and checksum.
//  A received byte is taken on each accepted transaction; the eighth one of a
//  status packet yields one read result through the queue and output register.
//  Commands enter while earlier packets drain, up to two descriptors queued.
//  Reset clears the control state; the status byte buffer is not cleared.
//  A stalled result holds in the output register; cmd.ready drops only when
//  the queue is full.
//
`default_nettype none

module servo_command_packet_framer_unit
    import scpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    scpf_cmd_if.sink   cmd,
    scpf_res_if.source res
);

    scpf_push_t  push;
    scpf_qstat_t qstat;
    scpf_desc_t  head;
    logic        pop;

    scpf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .qstat (qstat),
        .push  (push)
    );

    scpf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat),
        .head  (head)
    );

    scpf_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qstat (qstat),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

`default_nettype wire

@@ rtl/core/scpf_front.sv @@
// ============================================================================
// scpf_front
// Accepts command transactions, builds the packet body of each command and
// collects the status packet of an armed read, decoding it on its last byte.
// ============================================================================
`default_nettype none

module scpf_front
    import scpf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    scpf_cmd_if.sink   cmd,
    input  wire scpf_qstat_t qstat,
    output scpf_push_t push
);

    logic [2:0] pending_reg, pending_next;
    logic [7:0] expected_id_reg, expected_id_next;
    logic [2:0] rx_count_reg, rx_count_next;
    logic [7:0] rx_buffer_reg [STATUS_BYTES];
    logic       rx_wr;
    logic       accept;
    logic       status_ok;
    logic [15:0] load_mag;
    logic [15:0] status_value;
    logic [7:0] wr_addr;
    logic [7:0] wr_lo;
    logic [7:0] wr_hi;
    logic [7:0] rd_addr;
    logic [7:0] rd_len;

    assign cmd.ready = !qstat.full;
    assign accept    = cmd.valid && cmd.ready;

    // write target of the single-register commands
    always_comb
    begin
        unique case (cmd.operation)
            OP_POSITION:
            begin
                wr_addr = ADDR_GOAL_POS;
                wr_lo   = cmd.position_value[7:0];
                wr_hi   = cmd.position_value[15:8];
            end
            OP_SPEED:
            begin
                wr_addr = ADDR_SPEED;
                wr_lo   = cmd.speed_value[7:0];
                wr_hi   = cmd.speed_value[15:8];
            end
            OP_TORQUE:
            begin
                wr_addr = ADDR_TORQUE;
                wr_lo   = cmd.setting_value;
                wr_hi   = 8'h00;
            end
            default:
            begin
                wr_addr = ADDR_LED;
                wr_lo   = cmd.setting_value;
                wr_hi   = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.operation)
            OP_READ_ID:   begin rd_addr = ADDR_ID;        rd_len = 8'h01; end
            OP_READ_POS:  begin rd_addr = ADDR_PRES_POS;  rd_len = 8'h02; end
            OP_READ_TEMP: begin rd_addr = ADDR_PRES_TEMP; rd_len = 8'h01; end
            default:      begin rd_addr = ADDR_PRES_LOAD; rd_len = 8'h02; end
        endcase
    end

    // status decode, valid when the last status byte arrives
    assign status_ok = (rx_buffer_reg[0] == HDR_BYTE) && (rx_buffer_reg[1] == HDR_BYTE)
                       && (rx_buffer_reg[2] == expected_id_reg);
    assign load_mag  = {6'd0, rx_buffer_reg[6][1:0], rx_buffer_reg[5]};

    always_comb
    begin
        if (!status_ok)
        begin
            status_value = 16'd0;
        end
        else
        begin
            unique case (pending_reg)
                RD_ID, RD_TEMP: status_value = {8'd0, rx_buffer_reg[5]};
                RD_POS:         status_value = {rx_buffer_reg[6], rx_buffer_reg[5]};
                default:
                begin
                    // high status byte bits 7:2 all clear: report negative load
                    if (rx_buffer_reg[6][7:2] == 6'd0)
                        status_value = 16'd0 - load_mag;
                    else
                        status_value = load_mag;
                end
            endcase
        end
    end

    always_comb
    begin
        pending_next     = pending_reg;
        expected_id_next = expected_id_reg;
        rx_count_next    = rx_count_reg;
        rx_wr            = 1'b0;
        push             = '0;

        if (accept)
        begin
            unique case (cmd.operation) inside
                OP_SYNC_MOVE:
                begin
                    pending_next       = RD_NONE;
                    rx_count_next      = 3'd0;
                    push.valid         = 1'b1;
                    push.desc.body_len = 4'd10;
                    push.desc.body[0]  = BROADCAST_ID;
                    push.desc.body[1]  = LEN_SYNC;
                    push.desc.body[2]  = INST_SYNC;
                    push.desc.body[3]  = ADDR_GOAL_POS;
                    push.desc.body[4]  = SYNC_DATA_LEN;
                    push.desc.body[5]  = cmd.servo_id;
                    push.desc.body[6]  = cmd.position_value[7:0];
                    push.desc.body[7]  = cmd.position_value[15:8];
                    push.desc.body[8]  = cmd.speed_value[7:0];
                    push.desc.body[9]  = cmd.speed_value[15:8];
                end
                [OP_POSITION:OP_LED]:
                begin
                    pending_next       = RD_NONE;
                    rx_count_next      = 3'd0;
                    push.valid         = 1'b1;
                    push.desc.body_len = 4'd6;
                    push.desc.body[0]  = cmd.servo_id;
                    push.desc.body[1]  = LEN_WRITE_WORD;
                    push.desc.body[2]  = INST_WRITE;
                    push.desc.body[3]  = wr_addr;
                    push.desc.body[4]  = wr_lo;
                    push.desc.body[5]  = wr_hi;
                end
                OP_SET_ID:
                begin
                    pending_next       = RD_NONE;
                    rx_count_next      = 3'd0;
                    push.valid         = 1'b1;
                    push.desc.body_len = 4'd5;
                    push.desc.body[0]  = cmd.servo_id;
                    push.desc.body[1]  = LEN_SHORT;
                    push.desc.body[2]  = INST_WRITE;
                    push.desc.body[3]  = ADDR_ID;
                    push.desc.body[4]  = cmd.setting_value;
                end
                [OP_READ_ID:OP_READ_LOAD]:
                begin
                    // arm the receiver for this id
                    pending_next       = 3'(cmd.operation - OP_SET_ID);
                    expected_id_next   = cmd.servo_id;
                    rx_count_next      = 3'd0;
                    push.valid         = 1'b1;
                    push.desc.body_len = 4'd5;
                    push.desc.body[0]  = cmd.servo_id;
                    push.desc.body[1]  = LEN_SHORT;
                    push.desc.body[2]  = INST_READ;
                    push.desc.body[3]  = rd_addr;
                    push.desc.body[4]  = rd_len;
                end
                OP_RX_BYTE:
                begin
                    // drop stray bytes while no read is armed
                    if (pending_reg != RD_NONE)
                    begin
                        rx_wr = 1'b1;
                        if (rx_count_reg == 3'(STATUS_BYTES - 1))
                        begin
                            pending_next         = RD_NONE;
                            rx_count_next        = 3'd0;
                            push.valid           = 1'b1;
                            push.desc.is_read    = 1'b1;
                            push.desc.read_value = status_value;
                            push.desc.header_ok  = status_ok;
                        end
                        else
                        begin
                            rx_count_next = rx_count_reg + 3'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= RD_NONE;
            expected_id_reg <= 8'd0;
            rx_count_reg    <= 3'd0;
        end
        else
        begin
            pending_reg     <= pending_next;
            expected_id_reg <= expected_id_next;
            rx_count_reg    <= rx_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_wr)
            rx_buffer_reg[rx_count_reg] <= cmd.received_byte;
    end

endmodule

`default_nettype wire

@@ rtl/core/scpf_queue.sv @@
// ============================================================================
// scpf_queue
// Two-entry descriptor queue between the front and back parts.
// ============================================================================
`default_nettype none

module scpf_queue
    import scpf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire scpf_push_t push,
    input  wire logic   pop,
    output scpf_qstat_t qstat,
    output scpf_desc_t  head
);

    scpf_desc_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.full  = (count_reg == 2'd2);
    assign head        = entry_reg[rd_ptr_reg];

    assign do_push = push.valid && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.desc;
    end

endmodule

`default_nettype wire

@@ rtl/core/scpf_back.sv @@
// ============================================================================
// scpf_back
// Serializes the descriptor at the queue head: header, body and checksum for
// a packet, or a single read result, into the registered result channel.
// ============================================================================
`default_nettype none

module scpf_back
    import scpf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire scpf_qstat_t qstat,
    input  wire scpf_desc_t  head,
    output logic        pop,
    scpf_res_if.source  res
);

    logic [3:0]  byte_idx_reg, byte_idx_next;
    logic [7:0]  sum_reg, sum_next;
    logic        valid_reg, valid_next;
    logic        kind_reg, kind_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        last_reg, last_next;
    logic [15:0] read_value_reg, read_value_next;
    logic        header_ok_reg, header_ok_next;
    logic        advance;
    logic [3:0]  body_idx;
    logic [3:0]  cs_idx;
    logic [7:0]  body_byte;

    assign advance  = !qstat.empty && (!valid_reg || res.ready);
    assign body_idx = byte_idx_reg - 4'd2;
    assign cs_idx   = head.body_len + 4'd2;
    assign body_byte = (body_idx < 4'(BODY_MAX)) ? head.body[body_idx] : 8'h00;

    always_comb
    begin
        pop             = 1'b0;
        byte_idx_next   = byte_idx_reg;
        sum_next        = sum_reg;
        kind_next       = kind_reg;
        tx_byte_next    = tx_byte_reg;
        last_next       = last_reg;
        read_value_next = read_value_reg;
        header_ok_next  = header_ok_reg;
        valid_next      = res.ready ? 1'b0 : valid_reg;

        if (advance)
        begin
            valid_next      = 1'b1;
            kind_next       = head.is_read ? RESULT_READ : RESULT_TX;
            tx_byte_next    = 8'h00;
            last_next       = 1'b0;
            read_value_next = 16'd0;
            header_ok_next  = 1'b0;
            if (head.is_read)
            begin
                read_value_next = head.read_value;
                header_ok_next  = head.header_ok;
                pop             = 1'b1;
            end
            else if (byte_idx_reg < 4'd2)
            begin
                tx_byte_next  = HDR_BYTE;
                byte_idx_next = byte_idx_reg + 4'd1;
            end
            else if (byte_idx_reg == cs_idx)
            begin
                tx_byte_next  = ~sum_reg;
                last_next     = 1'b1;
                pop           = 1'b1;
            end
            else
            begin
                tx_byte_next  = body_byte;
                sum_next      = sum_reg + body_byte;
                byte_idx_next = byte_idx_reg + 4'd1;
            end

            // restart the byte walk on the next descriptor
            if (pop)
            begin
                byte_idx_next = 4'd0;
                sum_next      = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_idx_reg <= 4'd0;
            sum_reg      <= 8'd0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            sum_reg      <= sum_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        tx_byte_reg    <= tx_byte_next;
        last_reg       <= last_next;
        read_value_reg <= read_value_next;
        header_ok_reg  <= header_ok_next;
    end

    assign res.valid       = valid_reg;
    assign res.result_kind = kind_reg;
    assign res.tx_byte     = tx_byte_reg;
    assign res.last_byte   = last_reg;
    assign res.read_value  = read_value_reg;
    assign res.header_ok   = header_ok_reg;

endmodule

`default_nettype wire
